[rtl/connection_slot_table_defines.svh]
// Assertion macros for the connection slot table RTL.
`ifndef CONNECTION_SLOT_TABLE_DEFINES_SVH
`define CONNECTION_SLOT_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a condition on every clock edge outside reset.
`define CST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a consequence holds in the cycle after its trigger.
`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CST_ASSERT(lbl, prop, msg)
`define CST_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/cst_pkg.sv]
// Types and constants shared by the connection slot table.
`default_nettype none

package cst_pkg;

    // Table geometry
    localparam int SLOTS   = 64;
    localparam int IDX_W   = 6;
    localparam int CERT_W  = 32;
    localparam int DIST_W  = 32;
    localparam int MODE_W  = 2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // Input word
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  slot_index;
        logic [CERT_W-1:0] cert_in;
        logic [DIST_W-1:0] dist_handle_in;
    } t_cst_in;

    // Result word
    typedef struct packed {
        logic [IDX_W-1:0]  result_index;
        logic              ok;
        logic              active_out;
        logic [CERT_W-1:0] cert_out;
        logic [DIST_W-1:0] dist_handle_out;
    } t_cst_out;

endpackage

`default_nettype wire

[rtl/connection_slot_table.sv]
// Connection slot table: next-fit allocator with per-slot cert and handle store.
//
// Input channel (i_in_valid / o_in_stall / i_in_word) carries add, remove and
// query words; the result channel (o_out_valid / i_out_stall / o_out_word)
// returns exactly one word per input word, in order. The config channel
// (i_cfg_valid / o_cfg_ready / i_cfg_wdata) writes the invalid cert and is
// always ready; write it only while the table is idle.
//
// The accept cycle reads the cert/handle memory and registers the free-slot
// masks with their per-group summaries; the execute state then finishes the
// two-level next-fit encode, updates the active bits, cursor and memory, and
// loads the result register, or parks the result if that register is stalled.
// No new word is accepted until the previous one has left the execute state,
// and none while a parked result waits for the output register.
//
// A result word sits in the output register until taken; the next input word
// is accepted meanwhile. If a second result is ready while the first is still
// stalled, it is parked and input stalls until the output register frees up.
// Synchronous reset clears all active bits, the cursor and the invalid cert;
// the memory is not cleared, since reads are gated by the active bits.
`default_nettype none

module connection_slot_table (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire cst_pkg::t_cst_in i_in_word,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output cst_pkg::t_cst_out o_out_word,
    input  wire              i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire [cst_pkg::CERT_W-1:0] i_cfg_wdata
);
    import cst_pkg::*;

    `include "connection_slot_table_defines.svh"

    localparam int GRP_SIZE  = 8;
    localparam int GRP_CNT   = (SLOTS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PAD_W     = GRP_CNT * GRP_SIZE;
    localparam int GRP_IDX_W = $clog2(GRP_CNT);
    localparam int BIT_W     = $clog2(GRP_SIZE);
    localparam int MEM_W     = CERT_W + DIST_W;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_HOLD} t_state;

    t_state              r_state, n_state;
    t_cst_in             r_item;
    logic [PAD_W-1:0]    r_free_hi, r_free_all;
    logic [GRP_CNT-1:0]  r_grp_hi, r_grp_all;
    logic [MEM_W-1:0]    r_rd_data;
    logic [SLOTS-1:0]    r_active;
    logic [IDX_W-1:0]    r_cursor;
    logic [CERT_W-1:0]   r_invalid_cert;
    logic                r_out_valid, n_out_valid;
    t_cst_out            r_out_word, n_out_word;
    t_cst_out            r_res;
    logic [MEM_W-1:0]    mem_entries [SLOTS];

    logic                in_acc;
    logic                out_free;
    logic [PAD_W-1:0]    c_free_pad, c_free_hi, c_free_all;
    logic [GRP_CNT-1:0]  c_grp_hi, c_grp_all;
    logic                c_use_hi;
    logic [PAD_W-1:0]    c_vec;
    logic [GRP_CNT-1:0]  c_grps;
    logic                c_found;
    logic [GRP_IDX_W-1:0] c_grp;
    logic [GRP_SIZE-1:0] c_bits;
    logic [BIT_W-1:0]    c_bit;
    logic [IDX_W-1:0]    c_slot;
    logic                c_idx_valid;
    logic                c_hit;
    logic                c_exec;
    logic                c_add_hit;
    logic                c_add_miss;
    logic                c_rem_hit;
    t_cst_out            c_res;

    // Handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    // Build free masks from the cursor, slot 0 excluded
    always_comb begin
        c_free_pad    = PAD_W'(~r_active);
        c_free_pad[0] = 1'b0;
        for (int i = 0; i < PAD_W; i++) begin
            c_free_all[i] = c_free_pad[i];
            c_free_hi[i]  = c_free_pad[i] && (IDX_W'(i) >= r_cursor);
        end
        for (int g = 0; g < GRP_CNT; g++) begin
            c_grp_hi[g]  = |c_free_hi[g*GRP_SIZE +: GRP_SIZE];
            c_grp_all[g] = |c_free_all[g*GRP_SIZE +: GRP_SIZE];
        end
    end

    // Finish the encode: lowest free group, then lowest free bit in it
    always_comb begin
        c_use_hi = |r_grp_hi;
        c_vec    = c_use_hi ? r_free_hi : r_free_all;
        c_grps   = c_use_hi ? r_grp_hi : r_grp_all;
        c_found  = |c_grps;
        c_grp    = '0;
        for (int g = GRP_CNT - 1; g >= 0; g--) begin
            if (c_grps[g]) begin
                c_grp = GRP_IDX_W'(g);
            end
        end
        c_bits = c_vec[c_grp*GRP_SIZE +: GRP_SIZE];
        c_bit  = '0;
        for (int b = GRP_SIZE - 1; b >= 0; b--) begin
            if (c_bits[b]) begin
                c_bit = BIT_W'(b);
            end
        end
        c_slot = IDX_W'({c_grp, c_bit});
    end

    // Decode the held word and form its result
    always_comb begin
        c_idx_valid = (r_item.slot_index != '0) && (32'(r_item.slot_index) < SLOTS);
        c_hit       = c_idx_valid && r_active[r_item.slot_index];
        c_exec      = (r_state == S_EXEC);
        c_add_hit   = c_exec && (r_item.mode == MODE_ADD) && c_found;
        c_add_miss  = c_exec && (r_item.mode == MODE_ADD) && !c_found;
        c_rem_hit   = c_exec && (r_item.mode == MODE_REMOVE) && c_idx_valid;
        c_res       = '0;
        unique case (r_item.mode)
            MODE_ADD: begin
                c_res.result_index = c_found ? c_slot : '0;
                c_res.ok           = c_found;
            end
            MODE_REMOVE: begin
                c_res.ok = c_idx_valid;
            end
            MODE_QUERY: begin
                c_res.ok              = 1'b1;
                c_res.active_out      = c_hit;
                c_res.cert_out        = c_hit ? r_rd_data[MEM_W-1 -: CERT_W] : r_invalid_cert;
                c_res.dist_handle_out = c_hit ? r_rd_data[DIST_W-1:0] : '0;
            end
            default: begin
                c_res = '0;
            end
        endcase
    end

    // Sequence the word and steer the result register
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = c_res;
                    n_state     = S_IDLE;
                end else begin
                    n_out_valid = 1'b1;
                    n_state     = S_HOLD;
                end
            end
            S_HOLD: begin
                n_out_valid = 1'b1;
                if (out_free) begin
                    n_out_word = r_res;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, table flags, cursor, config and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_active       <= '0;
            r_cursor       <= '0;
            r_invalid_cert <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_out_word  <= n_out_word;
            if (i_cfg_valid) begin
                r_invalid_cert <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_item     <= i_in_word;
                r_free_hi  <= c_free_hi;
                r_free_all <= c_free_all;
                r_grp_hi   <= c_grp_hi;
                r_grp_all  <= c_grp_all;
            end
            if (c_exec) begin
                r_res <= c_res;
            end
            if (c_add_hit) begin
                r_active[c_slot] <= 1'b1;
                r_cursor         <= c_slot;
            end
            if (c_add_miss) begin
                r_cursor <= '0;
            end
            if (c_rem_hit) begin
                r_active[r_item.slot_index] <= 1'b0;
            end
        end
    end

    // Cert and handle memory: write on add, read on accept
    always_ff @(posedge i_clk) begin
        if (c_add_hit) begin
            mem_entries[c_slot] <= {r_item.cert_in, r_item.dist_handle_in};
        end
        if (in_acc) begin
            r_rd_data <= mem_entries[i_in_word.slot_index];
        end
    end

    `CST_ASSERT(a_slot0_never_active, !r_active[0], "reserved slot 0 marked active")
    `CST_ASSERT(a_add_slot_free, !c_add_hit || (c_slot != '0 && !r_active[c_slot]), "busy slot")
    `CST_ASSERT_NEXT(a_add_sets_active, c_add_hit, r_active[$past(c_slot)], "slot not active")
    `CST_ASSERT_NEXT(a_add_moves_cursor, c_add_hit, r_cursor == $past(c_slot), "cursor stuck")
    `CST_ASSERT_NEXT(a_full_parks_cursor, c_add_miss, r_cursor == '0, "cursor not parked")

endmodule

`default_nettype wire

[test/connection_slot_table_tb.sv]
// Self-checking testbench for the connection slot table: directed and random add/remove/query traffic.
`timescale 1ns / 1ps

module connection_slot_table_tb;

    import cst_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED    = 40;

    // Clock, reset and block ports
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                in_valid   = 1'b0;
    t_cst_in             in_word    = '0;
    logic                out_stall  = 1'b0;
    logic                cfg_valid  = 1'b0;
    logic [CERT_W-1:0]   cfg_wdata  = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    t_cst_out            o_out_word;
    logic                o_cfg_ready;

    // Words waiting for the driver and results waiting for the block
    t_cst_in  queued_ops[$];
    t_cst_out due_results[$];

    // Mirror of the table state
    logic [SLOTS-1:0]  slot_live = '0;
    logic [CERT_W-1:0] slot_cert [SLOTS];
    logic [DIST_W-1:0] slot_dist [SLOTS];
    logic [IDX_W-1:0]  scan_cursor = '0;
    logic [CERT_W-1:0] cert_when_empty = '0;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  in_taken      = 1'b0;
    int  idle_cycles   = 0;
    int  result_count  = 0;
    int  mismatch_count = 0;

    connection_slot_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_wdata (cfg_wdata)
    );

    // Toggle the clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at result %0d: %s got %h want %h", result_count, what, got, want);
    endtask

    // Apply one word to the mirrored table and return the result it produces
    function automatic t_cst_out apply_slot_op(input t_cst_in w);
        t_cst_out       r;
        logic [IDX_W-1:0] pos;
        logic           found;
        int             k;
        r     = '0;
        found = 1'b0;
        pos   = '0;
        case (w.mode)
            MODE_ADD: begin
                // Next-fit scan from the cursor, slot 0 never taken
                for (k = 0; k < SLOTS && !found; k++) begin
                    pos = scan_cursor + IDX_W'(k);
                    if (pos != '0 && !slot_live[pos])
                        found = 1'b1;
                end
                if (found) begin
                    scan_cursor     = pos;
                    slot_live[pos]  = 1'b1;
                    slot_cert[pos]  = w.cert_in;
                    slot_dist[pos]  = w.dist_handle_in;
                    r.result_index  = pos;
                    r.ok            = 1'b1;
                end else begin
                    scan_cursor = '0;
                end
            end
            MODE_REMOVE: begin
                if (w.slot_index != '0) begin
                    slot_live[w.slot_index] = 1'b0;
                    r.ok = 1'b1;
                end
            end
            MODE_QUERY: begin
                r.ok = 1'b1;
                if (w.slot_index != '0 && slot_live[w.slot_index]) begin
                    r.active_out      = 1'b1;
                    r.cert_out        = slot_cert[w.slot_index];
                    r.dist_handle_out = slot_dist[w.slot_index];
                end else begin
                    r.cert_out = cert_when_empty;
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_cst_in make_op(input logic [MODE_W-1:0] mode,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [CERT_W-1:0] cert,
                                        input logic [DIST_W-1:0] handle);
        t_cst_in w;
        w.mode           = mode;
        w.slot_index     = idx;
        w.cert_in        = cert;
        w.dist_handle_in = handle;
        return w;
    endfunction

    // Pick a slot index, mostly valid ones, now and then slot 0
    function automatic logic [IDX_W-1:0] pick_index();
        if ($urandom_range(99) < 88)
            return IDX_W'($urandom_range(SLOTS - 1, 1));
        return IDX_W'($urandom_range(SLOTS - 1, 0));
    endfunction

    // Build one random word with the given share of adds
    function automatic t_cst_in random_op(input int add_pct);
        logic [CERT_W-1:0] cert;
        logic [DIST_W-1:0] handle;
        int                sel;
        cert   = $urandom;
        handle = $urandom;
        sel  = $urandom_range(99);
        if (sel < 4)       cert = '1;
        else if (sel < 8)  cert = '0;
        else if (sel < 12) cert = cert_when_empty;
        sel = $urandom_range(99);
        if (sel < 4)       handle = '0;
        else if (sel < 8)  handle = '1;
        if ($urandom_range(99) < add_pct)
            return make_op(MODE_ADD, IDX_W'($urandom), cert, handle);
        sel = $urandom_range(99);
        if (sel < 58)
            return make_op(MODE_REMOVE, pick_index(), cert, handle);
        if (sel < 97)
            return make_op(MODE_QUERY, pick_index(), cert, handle);
        return make_op(MODE_UNUSED, IDX_W'($urandom), cert, handle);
    endfunction

    // Queue random traffic in bursts that each, at random, lean to filling or to draining the table
    task automatic queue_random_ops(input int count);
        int queued;
        int burst;
        int add_pct;
        int k;
        queued = 0;
        while (queued < count) begin
            burst   = $urandom_range(120, 30);
            add_pct = ($urandom_range(99) < 60) ? 80 : 15;
            for (k = 0; k < burst && queued < count; k++) begin
                queued_ops.push_back(random_op(add_pct));
                queued++;
            end
        end
    endtask

    // Directed words: field extremes, every operation, the corner cases
    task automatic queue_directed_ops();
        queued_ops.push_back(make_op(MODE_QUERY,  6'd0,  '0, '0));
        queued_ops.push_back(make_op(MODE_QUERY,  6'd63, '0, '0));
        queued_ops.push_back(make_op(MODE_REMOVE, 6'd0,  '0, '0));
        queued_ops.push_back(make_op(MODE_REMOVE, 6'd63, '1, '1));
        queued_ops.push_back(make_op(MODE_UNUSED, 6'd63, '1, '1));
        queued_ops.push_back(make_op(MODE_ADD,    6'd63, '1, '1));
        queued_ops.push_back(make_op(MODE_ADD,    6'd0,  '0, '0));
        queued_ops.push_back(make_op(MODE_ADD,    6'd21, $urandom, $urandom));
        queued_ops.push_back(make_op(MODE_QUERY,  6'd1,  '1, '1));
        queued_ops.push_back(make_op(MODE_QUERY,  6'd2,  '0, '0));
        queued_ops.push_back(make_op(MODE_QUERY,  6'd3,  '0, '0));
        queued_ops.push_back(make_op(MODE_REMOVE, 6'd2,  '0, '0));
        queued_ops.push_back(make_op(MODE_QUERY,  6'd2,  '0, '0));
        queued_ops.push_back(make_op(MODE_ADD,    6'd2,  32'h8000_0001, 32'h0000_0001));
        queued_ops.push_back(make_op(MODE_QUERY,  6'd4,  '0, '0));
        queued_ops.push_back(make_op(MODE_REMOVE, 6'd2,  '0, '0));
        queued_ops.push_back(make_op(MODE_REMOVE, 6'd2,  '0, '0));
        queued_ops.push_back(make_op(MODE_ADD,    6'd0,  $urandom, '0));
        queued_ops.push_back(make_op(MODE_QUERY,  6'd5,  '0, '0));
        queued_ops.push_back(make_op(MODE_REMOVE, 6'd1,  '0, '0));
        queued_ops.push_back(make_op(MODE_REMOVE, 6'd3,  '0, '0));
        queued_ops.push_back(make_op(MODE_QUERY,  6'd1,  '0, '0));
        queued_ops.push_back(make_op(MODE_UNUSED, 6'd0,  '0, '0));
    endtask

    // Hold until every queued word is taken and every result has come back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (queued_ops.size() != 0 || in_valid || due_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the invalid cert register while the table is idle
    task automatic write_invalid_cert(input logic [CERT_W-1:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Drive input words at the falling edge; hold a word until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (queued_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_word  <= queued_ops.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Sample both channels at the rising edge: check results, predict new ones
    always @(posedge i_clk) begin : sample
        t_cst_out want_word;
        bit       out_taken;
        bit       cfg_taken;
        if (!i_rst_n) begin
            in_taken    = 1'b0;
            idle_cycles = 0;
        end else begin
            in_taken  = in_valid && !o_in_stall;
            out_taken = o_out_valid && !out_stall;
            cfg_taken = cfg_valid && o_cfg_ready;

            // Compare the taken result word with the oldest prediction
            if (out_taken) begin
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result word", o_out_word.cert_out, '0);
                end else begin
                    want_word = due_results.pop_front();
                    if (o_out_word.result_index != want_word.result_index)
                        report_mismatch("result_index", 32'(o_out_word.result_index),
                                        32'(want_word.result_index));
                    if (o_out_word.ok != want_word.ok)
                        report_mismatch("ok", 32'(o_out_word.ok), 32'(want_word.ok));
                    if (o_out_word.active_out != want_word.active_out)
                        report_mismatch("active_out", 32'(o_out_word.active_out),
                                        32'(want_word.active_out));
                    if (o_out_word.cert_out != want_word.cert_out)
                        report_mismatch("cert_out", o_out_word.cert_out, want_word.cert_out);
                    if (o_out_word.dist_handle_out != want_word.dist_handle_out)
                        report_mismatch("dist_handle_out", o_out_word.dist_handle_out,
                                        want_word.dist_handle_out);
                end
                result_count++;
            end

            if (in_taken)
                due_results.push_back(apply_slot_op(in_word));

            if (cfg_taken)
                cert_when_empty = cfg_wdata;

            // End the run if nothing moves for too long
            if (in_taken || out_taken || cfg_taken)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** connection_slot_table: FAILED **");
                $finish;
            end
        end
    end

    // Sequence the run: reset, directed words, then three random phases
    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 23;
        recv_idle_pct = 50;
        queue_directed_ops();
        wait_drained();

        write_invalid_cert(32'hFFFF_FFFF);
        queue_random_ops(300);
        // Pause the sender until the table has answered everything
        wait_drained();
        queue_random_ops(300);
        wait_drained();

        send_idle_pct = 50;
        recv_idle_pct = 23;
        write_invalid_cert($urandom);
        queue_random_ops(600);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_invalid_cert(32'h0000_0000);
        queue_random_ops(600);
        wait_drained();

        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("** connection_slot_table: PASSED **");
        end else begin
            $display("** connection_slot_table: FAILED **");
        end
        $finish;
    end

endmodule
